FILE: hdl/pgs_pkg.sv
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared constants, widths, register codes and table builders for the
// Phong glossy specular shading pipeline.
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int FRAC_BITS       = 14;
  localparam int POW_TABLE_DEPTH = 256;
  localparam int TBL_BITS        = $clog2(POW_TABLE_DEPTH);

  localparam int IN_W   = 16;
  localparam int NL_W   = 2 * IN_W;
  localparam int SUM1_W = NL_W + 2;
  localparam int D_W    = SUM1_W - FRAC_BITS;
  localparam int ND_W   = IN_W + D_W;
  localparam int T_W    = ND_W + 1;
  localparam int LSH_W  = IN_W + FRAC_BITS;
  localparam int RS_W   = ((T_W > LSH_W) ? T_W : LSH_W) + 1;
  localparam int R_W    = RS_W - FRAC_BITS;
  localparam int RV_W   = R_W + IN_W;
  localparam int DS_W   = RV_W + 2;
  localparam int X_W    = DS_W - FRAC_BITS;
  localparam int XU_W   = X_W - 1;
  localparam int P_W    = $clog2(XU_W);
  localparam int FB_W   = $clog2(FRAC_BITS + 1);
  localparam int LG_W   = 18 + ((P_W > FB_W) ? P_W : FB_W);
  localparam int Q_W    = LG_W + 17;
  localparam int IP_W   = Q_W - 24;
  localparam int S_W    = IP_W + 1;
  localparam int EXP_W  = 31;
  localparam int SH_W   = 5;
  localparam int PW_W   = 2 * FRAC_BITS + 17;
  localparam int PR_W   = PW_W + 16;
  localparam int A_W    = FRAC_BITS + 17;
  localparam int CH_W   = A_W + 16;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEC_GAIN  = 3'd0,
    REG_TINT_RED   = 3'd1,
    REG_TINT_GREEN = 3'd2,
    REG_TINT_BLUE  = 3'd3,
    REG_SHININESS  = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] SPEC_GAIN_RST = 16'd0;
  localparam logic [15:0] TINT_RST      = 16'd16384;
  localparam logic [15:0] SHININESS_RST = 16'd256;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    v     = v_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bit_v) begin
        v   = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // log2(1 + idx/depth) in q.16, by repeated squaring of the mantissa
  function automatic logic [15:0] log_entry(input int idx);
    logic [63:0] m;
    logic [15:0] r;
    m = (64'd1 << 30) + ((64'(idx) << 30) >> TBL_BITS);
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        r[k] = 1'b1;
        m    = m >> 1;
      end
    end
    return r;
  endfunction

  // 2^(e/depth) in q30
  function automatic logic [EXP_W-1:0] exp_entry(input int e);
    logic [63:0] t;
    logic [63:0] c;
    logic [63:0] y;
    t = (64'(e) << 24) >> TBL_BITS;
    c = isqrt64(64'd1 << 61);
    y = 64'd1 << 30;
    for (int j = 1; j <= 24; j++) begin
      if (t[24-j]) begin
        y = (y * c) >> 30;
      end
      c = isqrt64(c << 30);
    end
    return y[EXP_W-1:0];
  endfunction

endpackage

FILE: hdl/pgs_pow.sv
// ----------------------------------------------------------------------------
// pgs_pow
// Raises the mirror-view cosine to the Phong exponent: leading-one search,
// table log2, multiply by the exponent, table exp2 and a clamped shift.
// ----------------------------------------------------------------------------
module pgs_pow (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pgs_pkg::XU_W-1:0]  in_x,
  input  logic                      in_hit,
  input  logic [15:0]               shin,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pgs_pkg::PW_W-1:0]  out_pw,
  output logic                      out_hit
);
  import pgs_pkg::*;

  localparam int P_MAX   = XU_W - 1;
  localparam int CLAMP_S = 2 * FRAC_BITS - 14;

  logic [15:0]      log_rom [POW_TABLE_DEPTH];
  logic [EXP_W-1:0] exp_rom [POW_TABLE_DEPTH];

  for (genvar g = 0; g < POW_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [15:0]      LOG_V = log_entry(g);
    localparam logic [EXP_W-1:0] EXP_V = exp_entry(g);
    assign log_rom[g] = LOG_V;
    assign exp_rom[g] = EXP_V;
  end

  logic [5:1] vld_r;
  logic [6:1] rdy;

  assign rdy[6] = out_ready;
  for (genvar k = 1; k <= 5; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end
  assign in_ready  = rdy[1];
  assign out_valid = vld_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 5; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 1: leading one
  logic [P_W-1:0]  p_nxt;
  logic [P_W-1:0]  p1_r;
  logic [XU_W-1:0] x1_r;
  logic [5:1]      hit_r;

  always_comb begin
    p_nxt = '0;
    for (int b = 0; b < XU_W; b++) begin
      if (in_x[b]) p_nxt = P_W'(b);
    end
  end

  // stage 2: table log2
  logic [XU_W-1:0]        xn;
  logic [TBL_BITS-1:0]    idx;
  logic signed [LG_W-1:0] pe;
  logic signed [LG_W-1:0] lg_nxt;
  logic signed [LG_W-1:0] lg2_r;

  always_comb begin
    xn     = x1_r << (P_W'(P_MAX) - p1_r);
    idx    = xn[XU_W-2 -: TBL_BITS];
    pe     = $signed(LG_W'(p1_r)) - $signed(LG_W'(FRAC_BITS));
    lg_nxt = (pe <<< 16) + $signed(LG_W'(log_rom[idx]));
  end

  // stage 3: times exponent
  logic signed [Q_W-1:0] q3_r;

  // stage 4: table exp2 and shift count
  logic signed [IP_W-1:0] ip;
  logic signed [S_W-1:0]  s_nxt;
  logic [TBL_BITS-1:0]    e_idx;
  logic signed [S_W-1:0]  s4_r;
  logic [EXP_W-1:0]       y4_r;

  always_comb begin
    ip    = $signed(q3_r[Q_W-1:24]);
    s_nxt = S_W'(ip) + S_W'(FRAC_BITS - 30);
    e_idx = q3_r[23 -: TBL_BITS];
  end

  // stage 5: scale by the integer part, clamped where the gain stage saturates anyway
  logic signed [S_W-1:0] nsh;
  logic [PW_W-1:0]       pw_nxt;
  logic [PW_W-1:0]       pw5_r;

  always_comb begin
    nsh = -s4_r;
    if (s4_r >= CLAMP_S) begin
      pw_nxt = {1'b1, {(PW_W-1){1'b0}}};
    end else if (s4_r >= 0) begin
      pw_nxt = PW_W'(y4_r) << s4_r[SH_W-1:0];
    end else if (s4_r <= -31) begin
      pw_nxt = '0;
    end else begin
      pw_nxt = PW_W'(y4_r) >> nsh[SH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1_r     <= p_nxt;
      x1_r     <= in_x;
      hit_r[1] <= in_hit;
    end
    if (rdy[2]) begin
      lg2_r    <= lg_nxt;
      hit_r[2] <= hit_r[1];
    end
    if (rdy[3]) begin
      q3_r     <= Q_W'(lg2_r) * Q_W'($signed({1'b0, shin}));
      hit_r[3] <= hit_r[2];
    end
    if (rdy[4]) begin
      s4_r     <= s_nxt;
      y4_r     <= exp_rom[e_idx];
      hit_r[4] <= hit_r[3];
    end
    if (rdy[5]) begin
      pw5_r    <= pw_nxt;
      hit_r[5] <= hit_r[4];
    end
  end

  assign out_pw  = pw5_r;
  assign out_hit = hit_r[5];

endmodule

FILE: hdl/phong_glossy_specular.sv
// ----------------------------------------------------------------------------
// phong_glossy_specular
// Phong specular term: mirror the light about the normal, dot with the view,
// raise to the shininess exponent and scale by gain and tint.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is taken every clock while the result side keeps
// up, and each beat passes through fourteen register stages: six for the
// mirror and dot products, five in the power unit, three for gain, tint and
// saturation. Every stage has its own valid bit, so a stalled result only
// holds the stages behind it that are full. Registers are written through
// the cfg port while no beat is in flight; the user ensures it, not the block.
module phong_glossy_specular (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_normal_x,
  input  logic signed [15:0]               in_normal_y,
  input  logic signed [15:0]               in_normal_z,
  input  logic signed [15:0]               in_light_x,
  input  logic signed [15:0]               in_light_y,
  input  logic signed [15:0]               in_light_z,
  input  logic signed [15:0]               in_view_x,
  input  logic signed [15:0]               in_view_y,
  input  logic signed [15:0]               in_view_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      out_red,
  output logic [15:0]                      out_green,
  output logic [15:0]                      out_blue,
  output logic                             out_lobe_hit,
  output logic                             out_clipped,
  input  logic                             cfg_we,
  input  logic [pgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import pgs_pkg::*;

  localparam int CV_W = CH_W - FRAC_BITS;
  localparam int PS_W = PR_W - FRAC_BITS;
  localparam logic [A_W-1:0] ACAP = {1'b1, {(A_W-1){1'b0}}};

  // configuration registers
  logic [15:0] spec_gain_r;
  logic [15:0] tint_r [3];
  logic [15:0] shin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_gain_r <= SPEC_GAIN_RST;
      tint_r[0]   <= TINT_RST;
      tint_r[1]   <= TINT_RST;
      tint_r[2]   <= TINT_RST;
      shin_r      <= SHININESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEC_GAIN:  spec_gain_r <= cfg_data;
        REG_TINT_RED:   tint_r[0]   <= cfg_data;
        REG_TINT_GREEN: tint_r[1]   <= cfg_data;
        REG_TINT_BLUE:  tint_r[2]   <= cfg_data;
        REG_SHININESS:  shin_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [IN_W-1:0] n_in [3];
  logic signed [IN_W-1:0] l_in [3];
  logic signed [IN_W-1:0] v_in [3];

  assign n_in[0] = in_normal_x;
  assign n_in[1] = in_normal_y;
  assign n_in[2] = in_normal_z;
  assign l_in[0] = in_light_x;
  assign l_in[1] = in_light_y;
  assign l_in[2] = in_light_z;
  assign v_in[0] = in_view_x;
  assign v_in[1] = in_view_y;
  assign v_in[2] = in_view_z;

  // front pipeline handshake
  logic       pow_in_ready;
  logic [6:1] vld_r;
  logic [7:1] rdy;

  assign rdy[7] = pow_in_ready;
  for (genvar k = 1; k <= 6; k++) begin : g_rdy
    assign rdy[k] = ~vld_r[k] | rdy[k+1];
  end
  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  logic signed [NL_W-1:0]  nl1_r [3];
  logic signed [IN_W-1:0]  n1_r  [3];
  logic signed [IN_W-1:0]  l1_r  [3];
  logic signed [IN_W-1:0]  v1_r  [3];
  logic signed [D_W-1:0]   d2_r;
  logic signed [IN_W-1:0]  n2_r  [3];
  logic signed [IN_W-1:0]  l2_r  [3];
  logic signed [IN_W-1:0]  v2_r  [3];
  logic signed [ND_W-1:0]  nd3_r [3];
  logic signed [IN_W-1:0]  l3_r  [3];
  logic signed [IN_W-1:0]  v3_r  [3];
  logic signed [R_W-1:0]   r4_r  [3];
  logic signed [IN_W-1:0]  v4_r  [3];
  logic signed [RV_W-1:0]  rv5_r [3];
  logic [XU_W-1:0]         x6_r;
  logic                    hit6_r;

  logic signed [SUM1_W-1:0] sum_nl;
  logic signed [RS_W-1:0]   rs     [3];
  logic signed [DS_W-1:0]   sum_rv;
  logic signed [X_W-1:0]    dot;

  always_comb begin
    sum_nl = SUM1_W'(nl1_r[0]) + SUM1_W'(nl1_r[1]) + SUM1_W'(nl1_r[2]);
    for (int i = 0; i < 3; i++) begin
      // mirror ray component: 2 n (n.l) - l
      rs[i] = (RS_W'(nd3_r[i]) <<< 1) - (RS_W'(l3_r[i]) <<< FRAC_BITS);
    end
    sum_rv = DS_W'(rv5_r[0]) + DS_W'(rv5_r[1]) + DS_W'(rv5_r[2]);
    dot    = $signed(sum_rv[DS_W-1:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        nl1_r[i] <= NL_W'(n_in[i]) * NL_W'(l_in[i]);
        n1_r[i]  <= n_in[i];
        l1_r[i]  <= l_in[i];
        v1_r[i]  <= v_in[i];
      end
    end
    if (rdy[2]) begin
      d2_r <= $signed(sum_nl[SUM1_W-1:FRAC_BITS]);
      n2_r <= n1_r;
      l2_r <= l1_r;
      v2_r <= v1_r;
    end
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        nd3_r[i] <= ND_W'(n2_r[i]) * ND_W'(d2_r);
      end
      l3_r <= l2_r;
      v3_r <= v2_r;
    end
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        r4_r[i] <= $signed(rs[i][RS_W-1:FRAC_BITS]);
      end
      v4_r <= v3_r;
    end
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        rv5_r[i] <= RV_W'(r4_r[i]) * RV_W'(v4_r[i]);
      end
    end
    if (rdy[6]) begin
      x6_r   <= dot[XU_W-1:0];
      hit6_r <= (dot > 0);
    end
  end

  // power unit
  logic            pow_out_valid;
  logic            pow_out_ready;
  logic [PW_W-1:0] pow_pw;
  logic            pow_hit;

  pgs_pow u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[6]),
    .in_ready  (pow_in_ready),
    .in_x      (x6_r),
    .in_hit    (hit6_r),
    .shin      (shin_r),
    .out_valid (pow_out_valid),
    .out_ready (pow_out_ready),
    .out_pw    (pow_pw),
    .out_hit   (pow_hit)
  );

  // back pipeline: gain, tint, saturation
  logic [3:1] bvld_r;
  logic [4:1] brdy;

  assign brdy[4] = out_ready;
  for (genvar k = 1; k <= 3; k++) begin : g_brdy
    assign brdy[k] = ~bvld_r[k] | brdy[k+1];
  end
  assign pow_out_ready = brdy[1];
  assign out_valid     = bvld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r <= '0;
    end else begin
      if (brdy[1]) bvld_r[1] <= pow_out_valid;
      for (int k = 2; k <= 3; k++) begin
        if (brdy[k]) bvld_r[k] <= bvld_r[k-1];
      end
    end
  end

  logic [PR_W-1:0] prod7_r;
  logic            hit7_r;
  logic [CH_W-1:0] ch8_r [3];
  logic            hit8_r;
  logic [15:0]     chan9_r [3];
  logic            hit9_r;
  logic            clip9_r;

  logic [PS_W-1:0] prod_sh;
  logic [A_W-1:0]  a_val;
  logic [CV_W-1:0] cv   [3];
  logic [2:0]      sat;
  logic [15:0]     chan_nxt [3];

  always_comb begin
    prod_sh = prod7_r[PR_W-1:FRAC_BITS];
    if (prod_sh > PS_W'(ACAP)) begin
      a_val = ACAP;
    end else begin
      a_val = prod_sh[A_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      cv[c]  = ch8_r[c][CH_W-1:FRAC_BITS];
      sat[c] = |cv[c][CV_W-1:16];
      if (!hit8_r) begin
        chan_nxt[c] = '0;
      end else if (sat[c]) begin
        chan_nxt[c] = 16'hFFFF;
      end else begin
        chan_nxt[c] = cv[c][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (brdy[1]) begin
      prod7_r <= PR_W'(pow_pw) * PR_W'(spec_gain_r);
      hit7_r  <= pow_hit;
    end
    if (brdy[2]) begin
      for (int c = 0; c < 3; c++) begin
        ch8_r[c] <= CH_W'(a_val) * CH_W'(tint_r[c]);
      end
      hit8_r <= hit7_r;
    end
    if (brdy[3]) begin
      chan9_r <= chan_nxt;
      hit9_r  <= hit8_r;
      clip9_r <= hit8_r & (|sat);
    end
  end

  assign out_red      = chan9_r[0];
  assign out_green    = chan9_r[1];
  assign out_blue     = chan9_r[2];
  assign out_lobe_hit = hit9_r;
  assign out_clipped  = clip9_r;

endmodule
